### rtl/vtpd_pkg.sv
// vtpd_pkg: shared types and constants for the vertex transform block.
// Used by every module under rtl; depends on nothing.
package vtpd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_REGS  = 8;
    localparam int REG_W     = 64;
    localparam int IDX_W     = 3;
    // quotient bits produced by the divider: enough for |t| << FRAC_BITS over 1
    localparam int QBITS     = 32 + FRAC_BITS;
    localparam int NUM_W     = 32 + FRAC_BITS;   // magnitude of t << FRAC_BITS
    localparam int DEN_W     = 32;               // magnitude of w

    localparam logic [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);

    // matrix register indexes: row r, columns 0/1 at 2r, columns 2/3 at 2r+1
    typedef enum logic [IDX_W-1:0] {
        ROW0_COLS01,
        ROW0_COLS23,
        ROW1_COLS01,
        ROW1_COLS23,
        ROW2_COLS01,
        ROW2_COLS23,
        ROW3_COLS01,
        ROW3_COLS23
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] color_r;
        logic signed [31:0] color_g;
        logic signed [31:0] color_b;
        logic               last_in;
    } vtx_in_t;

    typedef struct packed {
        logic signed [31:0] ndc_x;
        logic signed [31:0] ndc_y;
        logic signed [31:0] ndc_z;
        logic signed [31:0] out_r;
        logic signed [31:0] out_g;
        logic signed [31:0] out_b;
        logic               last_out;
    } vtx_out_t;

    // attributes carried alongside the position through every stage
    typedef struct packed {
        logic signed [31:0] r;
        logic signed [31:0] g;
        logic signed [31:0] b;
        logic               last;
    } attr_t;

    // saturate a 66-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (v > hi)
            sat32 = 32'sh7fffffff;
        else if (v < lo)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

endpackage

### rtl/vtpd_xform.sv
// vtpd_xform: matrix times (x,y,z,1) in three stages; stage 3 floors and saturates.
// Depends on vtpd_pkg.
module vtpd_xform (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  vtpd_pkg::vtx_in_t       in_item,
    input  logic [vtpd_pkg::REG_W-1:0] mat [vtpd_pkg::NUM_REGS],
    output logic                    out_valid,
    output logic signed [31:0]      t_out [4],
    output vtpd_pkg::attr_t         out_attr
);
    // stage 1: sixteen 32x32 products
    logic signed [63:0] prod_reg [4][4];
    logic               v1_reg;
    vtpd_pkg::attr_t    a1_reg;
    // stage 2: row sums
    logic signed [65:0] sum_reg [4];
    logic               v2_reg;
    vtpd_pkg::attr_t    a2_reg;
    // stage 3: floor and saturate
    logic signed [31:0] t_reg [4];
    logic               v3_reg;
    vtpd_pkg::attr_t    a3_reg;

    logic signed [31:0] vec [4];
    logic signed [31:0] m [4][4];

    always_comb
    begin
        vec[0] = in_item.pos_x;
        vec[1] = in_item.pos_y;
        vec[2] = in_item.pos_z;
        vec[3] = vtpd_pkg::ONE_Q;
        for (int r = 0; r < 4; r++)
        begin
            m[r][0] = mat[2*r][31:0];
            m[r][1] = mat[2*r][63:32];
            m[r][2] = mat[2*r+1][31:0];
            m[r][3] = mat[2*r+1][63:32];
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 4; c++)
                    prod_reg[r][c] <= m[r][c] * vec[c];
                // exact sum; low fraction bits carried, floored by arithmetic shift
                sum_reg[r] <= 66'(prod_reg[r][0]) + 66'(prod_reg[r][1])
                            + 66'(prod_reg[r][2]) + 66'(prod_reg[r][3]);
                t_reg[r] <= vtpd_pkg::sat32(sum_reg[r] >>> vtpd_pkg::FRAC_BITS);
            end
            a1_reg <= '{r: in_item.color_r, g: in_item.color_g,
                        b: in_item.color_b, last: in_item.last_in};
            a2_reg <= a1_reg;
            a3_reg <= a2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign t_out     = t_reg;
    assign out_attr  = a3_reg;
endmodule

### rtl/vtpd_div.sv
// vtpd_div: pipelined restoring divider for x, y, z over w, one quotient bit
// per stage, then sign fix and saturation. Depends on vtpd_pkg.
module vtpd_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [31:0]   t_in [4],
    input  vtpd_pkg::attr_t      in_attr,
    output logic                 out_valid,
    output vtpd_pkg::vtx_out_t   out_item
);
    localparam int N  = vtpd_pkg::QBITS;
    localparam int NW = vtpd_pkg::NUM_W;
    localparam int DW = vtpd_pkg::DEN_W;

    // per stage state: remainder, numerator bits left, quotient so far
    logic [DW:0]        rem_reg [N+1][3];
    logic [NW-1:0]      num_reg [N+1][3];
    logic [DW-1:0]      den_reg [N+1];
    logic [2:0]         neg_reg [N+1];
    logic               wz_reg  [N+1];
    logic signed [31:0] raw_reg [N+1][3];
    vtpd_pkg::attr_t    a_reg   [N+1];
    logic               v_reg   [N+1];

    logic signed [31:0] ndc [3];

    // stage 0: magnitudes and signs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= N; s++)
                v_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s <= N; s++)
                v_reg[s] <= v_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0] <= t_in[3][31] ? DW'(-33'(t_in[3])) : DW'(t_in[3]);
            wz_reg[0]  <= (t_in[3] == 32'sd0);
            a_reg[0]   <= in_attr;
            for (int k = 0; k < 3; k++)
            begin
                rem_reg[0][k] <= '0;
                num_reg[0][k] <= t_in[k][31]
                    ? NW'({-33'(t_in[k]), {vtpd_pkg::FRAC_BITS{1'b0}}})
                    : NW'({33'(t_in[k]), {vtpd_pkg::FRAC_BITS{1'b0}}});
                neg_reg[0][k] <= t_in[k][31] ^ t_in[3][31];
                raw_reg[0][k] <= t_in[k];
            end
            // one quotient bit per stage; quotient shifts into num low end
            for (int s = 1; s <= N; s++)
            begin
                den_reg[s] <= den_reg[s-1];
                wz_reg[s]  <= wz_reg[s-1];
                a_reg[s]   <= a_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
                for (int k = 0; k < 3; k++)
                begin
                    logic [DW+1:0] trial;
                    trial = {rem_reg[s-1][k], num_reg[s-1][k][NW-1]}
                          - {2'b00, den_reg[s-1]};
                    raw_reg[s][k] <= raw_reg[s-1][k];
                    if (!trial[DW+1])
                    begin
                        rem_reg[s][k] <= trial[DW:0];
                        num_reg[s][k] <= {num_reg[s-1][k][NW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[s][k] <= {rem_reg[s-1][k][DW-1:0],
                                          num_reg[s-1][k][NW-1]};
                        num_reg[s][k] <= {num_reg[s-1][k][NW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // sign fix and saturation on the final quotient; if w is 0, t passes
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic signed [65:0] q;
            q = 66'({1'b0, num_reg[N][k]});
            if (neg_reg[N][k])
                q = -q;
            ndc[k] = wz_reg[N] ? raw_reg[N][k] : vtpd_pkg::sat32(q);
        end
    end

    assign out_valid = v_reg[N];
    assign out_item  = '{ndc_x: ndc[0], ndc_y: ndc[1], ndc_z: ndc[2],
                         out_r: a_reg[N].r, out_g: a_reg[N].g,
                         out_b: a_reg[N].b, last_out: a_reg[N].last};
endmodule

### rtl/vertex_transform_perspective_divide_top.sv
// Top level of the vertex transform with perspective divide.
// Depends on vtpd_pkg, vtpd_xform and vtpd_div.
//
//   channel  | signals                          | transfer when
//   ---------+----------------------------------+------------------------
//   input    | in_valid, in_ready, in_data      | in_valid & in_ready
//   output   | out_valid, out_ready, out_data   | out_valid & out_ready
//   config   | cfg_we, cfg_index, cfg_data      | cfg_we
//
// The path is 3 transform stages plus 49 divider stages plus the output
// register; one vertex per cycle sustained while the output is taken.
// The whole pipe advances together; it holds when the output register is
// full and not taken. Reset clears valid bits and loads the identity matrix.
module vertex_transform_perspective_divide_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  vtpd_pkg::vtx_in_t          in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output vtpd_pkg::vtx_out_t         out_data,
    input  logic                       cfg_we,
    input  logic [vtpd_pkg::IDX_W-1:0] cfg_index,
    input  logic [vtpd_pkg::REG_W-1:0] cfg_data
);
    logic [vtpd_pkg::REG_W-1:0] mat_reg [vtpd_pkg::NUM_REGS];
    logic                       en;
    logic                       xf_valid;
    logic signed [31:0]         xf_t [4];
    vtpd_pkg::attr_t            xf_attr;
    logic                       dv_valid;
    vtpd_pkg::vtx_out_t         dv_item;
    logic                       ov_reg;
    vtpd_pkg::vtx_out_t         od_reg;

    // matrix registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[vtpd_pkg::ROW0_COLS01] <= 64'(vtpd_pkg::ONE_Q);
            mat_reg[vtpd_pkg::ROW0_COLS23] <= '0;
            mat_reg[vtpd_pkg::ROW1_COLS01] <= {vtpd_pkg::ONE_Q, 32'd0};
            mat_reg[vtpd_pkg::ROW1_COLS23] <= '0;
            mat_reg[vtpd_pkg::ROW2_COLS01] <= '0;
            mat_reg[vtpd_pkg::ROW2_COLS23] <= 64'(vtpd_pkg::ONE_Q);
            mat_reg[vtpd_pkg::ROW3_COLS01] <= '0;
            mat_reg[vtpd_pkg::ROW3_COLS23] <= {vtpd_pkg::ONE_Q, 32'd0};
        end
        else if (cfg_we)
        begin
            mat_reg[cfg_index] <= cfg_data;
        end
    end

    // pipe advances unless the output register is full and stalled
    assign en       = !ov_reg || out_ready;
    assign in_ready = en;

    vtpd_xform u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_item   (in_data),
        .mat       (mat_reg),
        .out_valid (xf_valid),
        .t_out     (xf_t),
        .out_attr  (xf_attr)
    );

    vtpd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (xf_valid),
        .t_in      (xf_t),
        .in_attr   (xf_attr),
        .out_valid (dv_valid),
        .out_item  (dv_item)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            od_reg <= dv_item;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;
endmodule

### rtl/vtpd_checker.sv
// vtpd_checker: port-level checks on the vertex transform top level.
// Depends on vtpd_pkg; bound to vertex_transform_perspective_divide_top.
module vtpd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input vtpd_pkg::vtx_out_t out_data
);
    // a held result keeps its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // the block only stalls input when output is backed up
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid right after reset");
endmodule

bind vertex_transform_perspective_divide_top vtpd_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
